// ===== rtl/rpa_pkg.sv =====
package rpa_pkg;

  localparam int TIME_W   = 32;
  localparam int ACC_W    = 24;
  localparam int VOLT_W   = 24;
  localparam int RATE_W   = 24;
  localparam int SCALE_W  = 16;
  localparam int TAB_W    = 16;
  localparam int MUL_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = 2'd1;

  localparam logic [RATE_W-1:0]  DECAY_RATE_RST    = 24'd52429;
  localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = 16'd400;

  // log2(e) in Q1.30
  localparam logic [MUL_W-1:0] LOG2E_Q30 = 32'd1549082005;
  // table entries are Q1.15
  localparam logic [6:0] EXP_Q15_SHIFT = 7'd15;
  localparam int MAX_TABLE_BITS = 12;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-idx / 2^bits) in Q1.15, built from repeated square roots of 1/2
  function automatic logic [TAB_W-1:0] exp_entry(int idx, int bits);
    logic [63:0] roots [MAX_TABLE_BITS];
    logic [63:0] p;
    roots[0] = isqrt64(64'h8000_0000_0000_0000);
    for (int k = 1; k < MAX_TABLE_BITS; k++) begin
      if (k < bits) begin
        roots[k] = isqrt64(roots[k-1] << 32);
      end else begin
        roots[k] = 64'd0;
      end
    end
    p = 64'h1_0000_0000;
    for (int b = 0; b < MAX_TABLE_BITS; b++) begin
      if (b < bits && ((idx >> b) & 1) != 0) begin
        p = (p * roots[bits-1-b] + 64'h8000_0000) >> 32;
      end
    end
    return TAB_W'((p + 64'h1_0000) >> 17);
  endfunction

endpackage

// ===== rtl/rpa_if.sv =====
interface rpa_photon_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] arrival_time;

  modport source (output valid, output action, output arrival_time, input ready);
  modport sink   (input valid, input action, input arrival_time, output ready);
endinterface

interface rpa_result_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] sample_time;
  logic [VOLT_W-1:0] voltage_uv;

  modport source (output valid, output sample_time, output voltage_uv, input ready);
  modport sink   (input valid, input sample_time, input voltage_uv, output ready);
endinterface

// ===== rtl/rpa_mul.sv =====
module rpa_mul (
  input  logic                           clk,
  input  logic [rpa_pkg::MUL_W-1:0]      a,
  input  logic [rpa_pkg::MUL_W-1:0]      b,
  output logic [2*rpa_pkg::MUL_W-1:0]    p
);
  import rpa_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/rc_pileup_pulse_accumulator_top.sv =====
// RC pileup accumulator. Each photon word decays the stored charge by
// exp(-decay_rate * dt), adds one packet and returns (arrival_time,
// voltage_scale * charge), saturated to 24 bits; a start word clears the
// state and returns (0, 0). One registered 32x32 multiplier is reused for
// the four products of a photon (rate*dt, *log2e, *2^-f table entry,
// *voltage_scale); a photon word steps through S_X, S_Y, S_D, S_N, S_V and
// S_O before ready returns, a start word through S_V and S_O. The output
// register lets the next word in while a result waits; the block only
// stalls at its last step if the previous result has not been taken yet.
module rc_pileup_pulse_accumulator_top #(
  parameter int EXP_TABLE_BITS = 8,
  parameter int ACC_FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]    reg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]   write_data,
  rpa_photon_if.sink                       photon,
  rpa_result_if.source                     result
);
  import rpa_pkg::*;

  localparam int TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int PROD_W     = ACC_W + TAB_W;
  localparam logic [ACC_W:0]  ACC_ONE   = (ACC_W+1)'(1) << ACC_FRAC_BITS;
  localparam logic [PROD_W:0] VOLT_HALF = (PROD_W+1)'(1) << (ACC_FRAC_BITS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_X    = 7'b0000010,
    S_Y    = 7'b0000100,
    S_D    = 7'b0001000,
    S_N    = 7'b0010000,
    S_V    = 7'b0100000,
    S_O    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [RATE_W-1:0]  decay_rate;
  logic [SCALE_W-1:0] voltage_scale;
  logic [TIME_W-1:0]  previous_time;
  logic [ACC_W-1:0]   accumulator;
  logic [TIME_W-1:0]  dt;
  logic [TIME_W-1:0]  time_hold;
  logic               decay_zero;
  logic [6:0]         shamt;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] prod;

  logic [TAB_W-1:0]   exp_tab [TABLE_SIZE];
  logic [TAB_W-1:0]   tab_val;

  logic               accept;
  logic               out_free;
  logic [PROD_W-1:0]  decayed;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  logic [PROD_W:0]    volt_round;
  logic [PROD_W:0]    volt_shift;
  logic [VOLT_W-1:0]  volt_sat;

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_tab
    localparam logic [TAB_W-1:0] ENTRY = exp_entry(i, EXP_TABLE_BITS);
    assign exp_tab[i] = ENTRY;
  end

  assign photon.ready = (state == S_IDLE);
  assign accept       = photon.valid && photon.ready;
  assign out_free     = !result.valid || result.ready;

  // fraction of the base-2 exponent sits at prod[53:30] after the log2e step
  assign tab_val = exp_tab[prod[53 -: EXP_TABLE_BITS]];

  rpa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_X: begin
        mul_a = MUL_W'(decay_rate);
        mul_b = dt;
      end
      S_Y: begin
        mul_a = MUL_W'(prod[28:0]);
        mul_b = LOG2E_Q30;
      end
      S_D: begin
        mul_a = MUL_W'(accumulator);
        mul_b = MUL_W'(tab_val);
      end
      // keep the voltage product in place while the output waits
      S_V, S_O: begin
        mul_a = MUL_W'(accumulator);
        mul_b = MUL_W'(voltage_scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    decayed = decay_zero ? '0 : (prod[PROD_W-1:0] >> shamt);
    // decayed never exceeds the old accumulator, so the low bits hold it
    acc_sum = {1'b0, decayed[ACC_W-1:0]} + ACC_ONE;
    acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

    volt_round = {1'b0, prod[PROD_W-1:0]} + VOLT_HALF;
    volt_shift = volt_round >> ACC_FRAC_BITS;
    volt_sat   = (|volt_shift[PROD_W:VOLT_W]) ? '1 : volt_shift[VOLT_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = photon.action ? S_V : S_X;
        end
      end
      S_X: state_next = S_Y;
      S_Y: state_next = S_D;
      S_D: state_next = S_N;
      S_N: state_next = S_V;
      S_V: state_next = S_O;
      S_O: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      decay_rate    <= DECAY_RATE_RST;
      voltage_scale <= VOLTAGE_SCALE_RST;
      previous_time <= '0;
      accumulator   <= '0;
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (write_enable) begin
        case (reg_index)
          REG_DECAY_RATE:    decay_rate    <= write_data[RATE_W-1:0];
          REG_VOLTAGE_SCALE: voltage_scale <= write_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (photon.action) begin
          previous_time <= '0;
          accumulator   <= '0;
        end else begin
          previous_time <= photon.arrival_time;
        end
      end

      if (state == S_N) begin
        accumulator <= acc_new;
      end

      if (state == S_O && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_hold <= photon.action ? '0 : photon.arrival_time;
      // time running backwards means no decay
      dt <= (photon.arrival_time >= previous_time) ?
            (photon.arrival_time - previous_time) : '0;
    end
    if (state == S_Y) begin
      // 32 nepers or more decays to nothing
      decay_zero <= |prod[2*MUL_W-1:29];
    end
    if (state == S_D) begin
      shamt <= EXP_Q15_SHIFT + {1'b0, prod[59:54]};
    end
    if (state == S_O && out_free) begin
      result.sample_time <= time_hold;
      result.voltage_uv  <= volt_sat;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rpa_pkg::*;

  localparam int EXP_BITS   = 8;
  localparam int TABLE_SIZE = 1 << EXP_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES = 8;

  localparam logic ACT_PHOTON = 1'b0;
  localparam logic ACT_START  = 1'b1;

  // indexes past the last register: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [RATE_W-1:0]  RATE_AFTER_RESET  = 24'd52429;
  localparam logic [SCALE_W-1:0] SCALE_AFTER_RESET = 16'd400;
  localparam logic [63:0] LOG2E_Q1_30 = 64'd1549082005;
  localparam logic [63:0] DECAY_CUTOFF = 64'd32 << 24;
  localparam logic [63:0] CHARGE_MAX = 64'hFF_FFFF;
  localparam logic [63:0] VOLT_MAX = 64'hFF_FFFF;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [VOLT_W-1:0] voltage_uv;
  } sample_t;

  typedef struct packed {
    logic              act;
    logic [TIME_W-1:0] arrival;
    bit                typed;
    sample_t           want;
  } script_row_t;

  localparam int SCRIPT_LEN = 18;

  // typed rows follow from the reset settings: 400 uV per packet
  script_row_t pulse_script [SCRIPT_LEN] = '{
    '{ACT_PHOTON, 32'd0,          1'b1, '{32'd0, 24'd400}},
    '{ACT_PHOTON, 32'd0,          1'b1, '{32'd0, 24'd800}},
    '{ACT_PHOTON, 32'd100,        1'b0, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'd50,         1'b0, '{32'd0, 24'd0}},
    '{ACT_START,  32'hFFFF_FFFF,  1'b1, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'hFFFF_FFFF,  1'b1, '{32'hFFFF_FFFF, 24'd400}},
    '{ACT_PHOTON, 32'd0,          1'b1, '{32'd0, 24'd800}},
    '{ACT_PHOTON, 32'd1,          1'b0, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'd2,          1'b0, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'd320,        1'b0, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'h8000_0000,  1'b1, '{32'h8000_0000, 24'd400}},
    '{ACT_PHOTON, 32'h8000_0000,  1'b0, '{32'd0, 24'd0}},
    '{ACT_START,  32'd0,          1'b1, '{32'd0, 24'd0}},
    '{ACT_START,  32'h5555_5555,  1'b1, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'hAAAA_AAAA,  1'b1, '{32'hAAAA_AAAA, 24'd400}},
    '{ACT_PHOTON, 32'hAAAA_AAAB,  1'b0, '{32'd0, 24'd0}},
    '{ACT_PHOTON, 32'hAAAA_AAC0,  1'b0, '{32'd0, 24'd0}},
    '{ACT_START,  32'd0,          1'b1, '{32'd0, 24'd0}}
  };

  logic clk = 1'b0;
  logic rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  rpa_photon_if photon_bus ();
  rpa_result_if result_bus ();

  rc_pileup_pulse_accumulator_top #(
    .EXP_TABLE_BITS(EXP_BITS),
    .ACC_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .photon      (photon_bus),
    .result      (result_bus)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0]        exp_frac [TABLE_SIZE];
  logic [RATE_W-1:0]  model_rate;
  logic [SCALE_W-1:0] model_scale;
  logic [TIME_W-1:0]  last_arrival;
  logic [ACC_W-1:0]   charge;

  sample_t pending_samples [$];

  bit steady_flow;
  int hold_count;
  int cycle_count;
  int error_count;
  int checked_count;
  int start_count;
  int photon_count;
  int saturation_count;
  int setting_count;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = v;
    root  = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // entry i = 2^(-i/TABLE_SIZE) in Q1.15, from chained square roots of 1/2
  function automatic void build_exp_table();
    logic [63:0] roots [EXP_BITS];
    logic [63:0] p;
    roots[0] = floor_sqrt(64'd1 << 63);
    for (int k = 1; k < EXP_BITS; k++) roots[k] = floor_sqrt(roots[k-1] << 32);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      p = 64'd1 << 32;
      for (int b = 0; b < EXP_BITS; b++) begin
        if (((i >> b) & 1) != 0) p = (p * roots[EXP_BITS-1-b] + (64'd1 << 31)) >> 32;
      end
      exp_frac[i] = 16'((p + (64'd1 << 16)) >> 17);
    end
  endfunction

  function automatic sample_t next_sample(logic act, logic [TIME_W-1:0] t);
    sample_t s;
    logic [TIME_W-1:0] dt;
    logic [63:0] x, y, decayed, acc, volts;
    int n;
    int idx;
    if (act == ACT_START) begin
      last_arrival = '0;
      charge = '0;
      s.sample_time = '0;
      s.voltage_uv = '0;
      return s;
    end
    dt = (t >= last_arrival) ? t - last_arrival : '0;
    x = 64'(model_rate) * 64'(dt);
    if (x >= DECAY_CUTOFF) begin
      decayed = 64'd0;
    end else begin
      y = (x * LOG2E_Q1_30) >> 30;
      n = int'(y >> 24);
      idx = int'((y >> (24 - EXP_BITS)) & 64'(TABLE_SIZE - 1));
      decayed = (64'(charge) * 64'(exp_frac[idx])) >> (15 + n);
    end
    acc = decayed + (64'd1 << FRAC_BITS);
    if (acc > CHARGE_MAX) begin
      acc = CHARGE_MAX;
      saturation_count++;
    end
    charge = ACC_W'(acc);
    last_arrival = t;
    volts = (acc * 64'(model_scale) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (volts > VOLT_MAX) volts = VOLT_MAX;
    s.sample_time = t;
    s.voltage_uv = VOLT_W'(volts);
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // valid stays up across back-to-back words; it drops for a gap and in wait_drained
  task automatic send_word(logic act, logic [TIME_W-1:0] t, bit typed, sample_t want);
    int gap;
    sample_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      photon_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    photon_bus.valid <= 1'b1;
    photon_bus.action <= act;
    photon_bus.arrival_time <= t;
    @(posedge clk);
    while (!photon_bus.ready) @(posedge clk);
    predicted = next_sample(act, t);
    pending_samples.insert(pending_samples.size(), typed ? want : predicted);
    if (act == ACT_START) start_count++;
    else photon_count++;
  endtask

  task automatic wait_drained();
    photon_bus.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(logic [RATE_W-1:0] rate, logic [SCALE_W-1:0] scale);
    logic [CFG_IDX_W-1:0] spare;
    spare = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= REG_DECAY_RATE;
    write_data <= CFG_DATA_W'(rate);
    @(posedge clk);
    reg_index <= REG_VOLTAGE_SCALE;
    write_data <= CFG_DATA_W'(scale);
    @(posedge clk);
    reg_index <= spare;
    write_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    write_enable <= 1'b0;
    model_rate = rate;
    model_scale = scale;
    setting_count++;
  endtask

  // result side: random back-pressure, short holds mostly, a few long ones
  always @(posedge clk) begin
    if (steady_flow) begin
      result_bus.ready <= 1'b1;
    end else if (hold_count > 0) begin
      result_bus.ready <= 1'b0;
      hold_count--;
    end else if ($urandom_range(0, 99) < 65) begin
      result_bus.ready <= 1'b1;
    end else begin
      result_bus.ready <= 1'b0;
      hold_count = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2) : $urandom_range(15, 45);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result word: time %0d voltage %0d", $time,
                 result_bus.sample_time, result_bus.voltage_uv);
        error_count++;
      end else begin
        want = pending_samples.pop_front();
        checked_count++;
        if (result_bus.sample_time !== want.sample_time) begin
          $display("%0t: sample_time mismatch: expected %0d, got %0d", $time,
                   want.sample_time, result_bus.sample_time);
          error_count++;
        end
        if (result_bus.voltage_uv !== want.voltage_uv) begin
          $display("%0t: voltage_uv mismatch at time %0d: expected %0d, got %0d", $time,
                   want.sample_time, want.voltage_uv, result_bus.voltage_uv);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_samples.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t;
    logic [RATE_W-1:0] rate;
    logic [SCALE_W-1:0] scale;
    int word_total;
    int start_pct;
    int r;
    sample_t none;

    none = '0;
    error_count = 0;
    checked_count = 0;
    start_count = 0;
    photon_count = 0;
    saturation_count = 0;
    setting_count = 0;
    hold_count = 0;
    steady_flow = 1'b0;
    build_exp_table();
    model_rate = RATE_AFTER_RESET;
    model_scale = SCALE_AFTER_RESET;
    last_arrival = '0;
    charge = '0;

    rst <= 1'b1;
    write_enable <= 1'b0;
    reg_index <= REG_DECAY_RATE;
    write_data <= '0;
    photon_bus.valid <= 1'b0;
    photon_bus.action <= ACT_PHOTON;
    photon_bus.arrival_time <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pulse_script[i]) begin
      send_word(pulse_script[i].act, pulse_script[i].arrival, pulse_script[i].typed,
                pulse_script[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          // no decay, full scale: charge climbs into saturation
          rate = '0;
          scale = 16'hFFFF;
        end
        1: begin
          rate = 24'hFF_FFFF;
          scale = '0;
        end
        2: begin
          rate = 24'd1;
          scale = 16'd1;
        end
        3: begin
          rate = RATE_AFTER_RESET;
          scale = SCALE_AFTER_RESET;
        end
        default: begin
          rate = RATE_W'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 23));
          scale = SCALE_W'($urandom_range(0, 16'hFFFF));
        end
      endcase
      apply_settings(rate, scale);
      steady_flow = (phase == 2 || phase == 5);
      start_pct = (phase == 0) ? 0 : (phase == 1) ? 5 : 3;
      word_total = (phase == 0) ? 300 : 171;
      t = last_arrival;
      for (int w = 0; w < word_total; w++) begin
        if ($urandom_range(0, 99) < start_pct) begin
          send_word(ACT_START, TIME_W'($urandom), 1'b0, none);
          t = '0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 15) t = t;
          else if (r < 60) t = t + TIME_W'($urandom_range(0, 63));
          else if (r < 85) t = t + TIME_W'($urandom_range(0, 4095));
          else if (r < 95) t = t + TIME_W'($urandom_range(0, 1 << 20));
          else t = TIME_W'($urandom);
          send_word(ACT_PHOTON, t, 1'b0, none);
        end
      end
    end

    steady_flow = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d photon and %0d start words over %0d register settings",
             photon_count, start_count, setting_count);
    $display("Checked %0d results, %0d with the charge saturated, %0d errors",
             checked_count, saturation_count, error_count);
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
